// ===== sv/free_list_node_allocator_defines.svh =====
// Assertion macros for the free list node allocator.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef FREE_LIST_NODE_ALLOCATOR_DEFINES_SVH
`define FREE_LIST_NODE_ALLOCATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define FNA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define FNA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FNA_ASSERT(lbl, clk, rst, prop, msg)
`define FNA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== sv/fna_pkg.sv =====
// Shared types and constants for the free list node allocator.
// No dependencies; imported by fna_alu, fna_ctrl and the top level (fna_ram does not use it).
`timescale 1ns / 1ps

package fna_pkg;

  localparam int NODES_DEFAULT = 256;
  localparam int NODE_CAP      = 256;
  localparam int IDX_W         = 8;
  localparam int CNT_W         = 9;
  localparam int LINK_W        = 9;

  localparam logic [LINK_W-1:0] NULL_LINK  = 9'h100;
  localparam logic [CNT_W-1:0]  POOL_RESET = 9'd256;

  typedef enum logic [2:0] {
    ACT_INIT     = 3'd0,
    ACT_POP      = 3'd1,
    ACT_PUSH     = 3'd2,
    ACT_SPLICE   = 3'd3,
    ACT_SET_LINK = 3'd4
  } action_t;

  typedef enum logic {
    ALU_ADD_SAT = 1'b0,
    ALU_DEC     = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [CNT_W-1:0] a;
    logic [CNT_W-1:0] b;
  } alu_req_t;

  function automatic int limit_of(input int nodes);
    return (nodes < NODE_CAP) ? nodes : NODE_CAP;
  endfunction

endpackage

// ===== sv/fna_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fna_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/fna_alu.sv =====
// Shared count unit: saturating add and floored decrement.
// Depends on fna_pkg.
`timescale 1ns / 1ps

module fna_alu #(
  parameter int NODES = fna_pkg::NODES_DEFAULT
) (
  input  fna_pkg::alu_req_t         req,
  output logic [fna_pkg::CNT_W-1:0] res
);

  import fna_pkg::*;

  localparam int LIMIT = limit_of(NODES);
  localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(LIMIT);

  logic [CNT_W:0] sum;

  assign sum = {1'b0, req.a} + {1'b0, req.b};

  always_comb begin
    case (req.op)
      ALU_ADD_SAT: res = (sum > {1'b0, LIMIT_C}) ? LIMIT_C : sum[CNT_W-1:0];
      ALU_DEC:     res = (req.a == '0) ? '0 : req.a - CNT_W'(1);
      default:     res = req.a;
    endcase
  end

endmodule

// ===== sv/fna_ctrl.sv =====
// Sequencer for the free list: head, count, init walk and pop read.
// Depends on fna_pkg and free_list_node_allocator_defines.svh.
`timescale 1ns / 1ps

`include "free_list_node_allocator_defines.svh"

module fna_ctrl #(
  parameter int NODES = fna_pkg::NODES_DEFAULT,
  parameter int AW    = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 action,
  input  logic [fna_pkg::IDX_W-1:0]  node_index,
  input  logic [fna_pkg::IDX_W-1:0]  other_node,
  input  logic                       link_to_null,
  input  logic [fna_pkg::CNT_W-1:0]  slice_count,
  input  logic [fna_pkg::CNT_W-1:0]  pool_size,
  output logic                       done,
  output logic                       ok,
  output logic [fna_pkg::IDX_W-1:0]  popped_node,
  output logic [fna_pkg::CNT_W-1:0]  free_count,
  output logic                       list_empty,
  output logic                       mem_we,
  output logic [AW-1:0]              mem_waddr,
  output logic [fna_pkg::LINK_W-1:0] mem_wdata,
  output logic [AW-1:0]              mem_raddr,
  input  logic [fna_pkg::LINK_W-1:0] mem_rdata,
  output fna_pkg::alu_req_t          alu_req,
  input  logic [fna_pkg::CNT_W-1:0]  alu_res
);

  import fna_pkg::*;

  localparam int LIMIT = limit_of(NODES);
  localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(LIMIT);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_INIT,
    ST_POP
  } state_t;

  state_t             state;
  logic [2:0]         act;
  logic [IDX_W-1:0]   nd;
  logic [IDX_W-1:0]   oth;
  logic               to_null;
  logic [CNT_W-1:0]   slc;
  logic [IDX_W-1:0]   head;
  logic               head_valid;
  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   prev;
  logic [IDX_W-1:0]   last;

  logic               node_ok;
  logic               other_ok;
  logic [CNT_W-1:0]   init_n;
  logic [IDX_W-1:0]   init_last;
  logic [LINK_W-1:0]  head_link;

  assign node_ok   = {1'b0, nd} < LIMIT_C;
  assign other_ok  = {1'b0, oth} < LIMIT_C;
  assign init_n    = (pool_size > LIMIT_C) ? LIMIT_C : pool_size;
  assign init_last = init_n[IDX_W-1:0] - IDX_W'(1);
  assign head_link = head_valid ? {1'b0, head} : NULL_LINK;

  assign free_count = count;
  assign list_empty = !head_valid;
  assign mem_raddr  = head[AW-1:0];

  always_comb begin
    alu_req.op = ALU_ADD_SAT;
    alu_req.a  = count;
    alu_req.b  = CNT_W'(1);
    mem_we     = 1'b0;
    mem_waddr  = nd[AW-1:0];
    mem_wdata  = NULL_LINK;
    case (state)
      ST_EXEC: begin
        case (act)
          ACT_INIT: begin
            mem_waddr = '0;
            mem_we    = (pool_size != '0);
          end
          ACT_PUSH: begin
            mem_wdata = head_link;
            mem_we    = node_ok;
          end
          ACT_SPLICE: begin
            alu_req.b = slc;
            mem_wdata = head_link;
            mem_we    = node_ok && other_ok;
          end
          ACT_SET_LINK: begin
            mem_wdata = to_null ? NULL_LINK : {1'b0, oth};
            mem_we    = node_ok && (to_null || other_ok);
          end
          default: begin
            mem_we = 1'b0;
          end
        endcase
      end
      ST_INIT: begin
        alu_req.a = {1'b0, idx};
        mem_waddr = idx[AW-1:0];
        mem_wdata = {1'b0, prev};
        mem_we    = 1'b1;
      end
      ST_POP: begin
        alu_req.op = ALU_DEC;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      busy        <= 1'b0;
      done        <= 1'b0;
      ok          <= 1'b0;
      popped_node <= '0;
      head        <= '0;
      head_valid  <= 1'b0;
      count       <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            act         <= action;
            nd          <= node_index;
            oth         <= other_node;
            to_null     <= link_to_null;
            slc         <= slice_count;
            popped_node <= '0;
            busy        <= 1'b1;
            state       <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          case (act)
            ACT_INIT: begin
              if (pool_size == '0) begin
                ok    <= 1'b0;
                done  <= 1'b1;
                busy  <= 1'b0;
                state <= ST_IDLE;
              end else begin
                head       <= init_last;
                head_valid <= 1'b1;
                count      <= init_n;
                if (init_last == '0) begin
                  ok    <= 1'b1;
                  done  <= 1'b1;
                  busy  <= 1'b0;
                  state <= ST_IDLE;
                end else begin
                  idx   <= IDX_W'(1);
                  prev  <= '0;
                  last  <= init_last;
                  state <= ST_INIT;
                end
              end
            end
            ACT_POP: begin
              if (head_valid) begin
                state <= ST_POP;
              end else begin
                ok    <= 1'b0;
                done  <= 1'b1;
                busy  <= 1'b0;
                state <= ST_IDLE;
              end
            end
            ACT_PUSH: begin
              if (node_ok) begin
                head       <= nd;
                head_valid <= 1'b1;
                count      <= alu_res;
              end
              ok    <= node_ok;
              done  <= 1'b1;
              busy  <= 1'b0;
              state <= ST_IDLE;
            end
            ACT_SPLICE: begin
              if (node_ok && other_ok) begin
                head       <= oth;
                head_valid <= 1'b1;
                count      <= alu_res;
              end
              ok    <= node_ok && other_ok;
              done  <= 1'b1;
              busy  <= 1'b0;
              state <= ST_IDLE;
            end
            ACT_SET_LINK: begin
              ok    <= node_ok && (to_null || other_ok);
              done  <= 1'b1;
              busy  <= 1'b0;
              state <= ST_IDLE;
            end
            default: begin
              ok    <= 1'b0;
              done  <= 1'b1;
              busy  <= 1'b0;
              state <= ST_IDLE;
            end
          endcase
        end
        ST_INIT: begin
          if (idx == last) begin
            ok    <= 1'b1;
            done  <= 1'b1;
            busy  <= 1'b0;
            state <= ST_IDLE;
          end else begin
            prev <= idx;
            idx  <= alu_res[IDX_W-1:0];
          end
        end
        ST_POP: begin
          popped_node <= head;
          if (mem_rdata[LINK_W-1]) begin
            head_valid <= 1'b0;
            head       <= '0;
          end else begin
            head <= mem_rdata[IDX_W-1:0];
          end
          count <= alu_res;
          ok    <= 1'b1;
          done  <= 1'b1;
          busy  <= 1'b0;
          state <= ST_IDLE;
        end
        default: begin
          busy  <= 1'b0;
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `FNA_ASSERT(a_strobe_single, clk, rst, done |=> !done, "result strobe held twice")
  `FNA_ASSERT(a_done_idle, clk, rst, done |-> (!busy && state == ST_IDLE), "result while busy")
  `FNA_ASSERT_ALWAYS(a_count_cap, clk, rst || count <= LIMIT_C, "free count above node limit")
  `FNA_ASSERT(a_empty_by_pop, clk, rst, $fell(head_valid) |-> ($past(state == ST_POP) || $past(rst)), "list emptied outside pop")

endmodule

// ===== sv/free_list_node_allocator.sv =====
// Top level of the free list node allocator: config register, sequencer,
// shared count unit and link RAM. Depends on fna_pkg, fna_ctrl, fna_alu, fna_ram.
//
//   channel   handshake                    payload
//   ------    ---------------------------  ------------------------------------------
//   item in   start & !busy                action node_index other_node
//                                          link_to_null slice_count
//   result    done (one cycle, no stall)   ok popped_node free_count list_empty
//   config    cfg_valid & cfg_ready        cfg_data (pool_size)
//
// Push, splice, set_link and rejected items: result set from the ST_EXEC state.
// Pop: result set from ST_POP after ST_EXEC; the head's link comes from the RAM read port.
// Init: ST_EXEC places node 0, then ST_INIT places the rest, one RAM write per cycle.
// Next item may start in the cycle the result shows; reset empties the list.
`timescale 1ns / 1ps

module free_list_node_allocator #(
  parameter int NODES = fna_pkg::NODES_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                action,
  input  logic [fna_pkg::IDX_W-1:0] node_index,
  input  logic [fna_pkg::IDX_W-1:0] other_node,
  input  logic                      link_to_null,
  input  logic [fna_pkg::CNT_W-1:0] slice_count,
  output logic                      done,
  output logic                      ok,
  output logic [fna_pkg::IDX_W-1:0] popped_node,
  output logic [fna_pkg::CNT_W-1:0] free_count,
  output logic                      list_empty,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [fna_pkg::CNT_W-1:0] cfg_data
);

  import fna_pkg::*;

  localparam int LIMIT = limit_of(NODES);
  localparam int AW    = $clog2(LIMIT);

  logic [CNT_W-1:0]  pool_size;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [LINK_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [LINK_W-1:0] mem_rdata;
  alu_req_t          alu_req;
  logic [CNT_W-1:0]  alu_res;

  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size <= POOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      pool_size <= cfg_data;
    end
  end

  fna_ctrl #(
    .NODES (NODES),
    .AW    (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .node_index   (node_index),
    .other_node   (other_node),
    .link_to_null (link_to_null),
    .slice_count  (slice_count),
    .pool_size    (pool_size),
    .done         (done),
    .ok           (ok),
    .popped_node  (popped_node),
    .free_count   (free_count),
    .list_empty   (list_empty),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata),
    .alu_req      (alu_req),
    .alu_res      (alu_res)
  );

  fna_alu #(
    .NODES (NODES)
  ) u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  fna_ram #(
    .WIDTH (LINK_W),
    .DEPTH (LIMIT)
  ) u_link_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ===== verif/free_list_node_allocator_tb.sv =====
// Self-checking testbench for free_list_node_allocator: directed table, then random phases.
// Each phase writes pool_size, then sends init/pop/push/splice/set_link and invalid action items.
// Depends on fna_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module free_list_node_allocator_tb;
  import fna_pkg::*;

  localparam int NODE_LIMIT  = NODE_CAP;
  localparam int NO_CFG      = -1;
  localparam int RANDOM_POOL = -2;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 150;
  localparam logic [2:0] ACT_BAD_LO  = 3'd5;
  localparam logic [2:0] ACT_BAD_MID = 3'd6;
  localparam logic [2:0] ACT_BAD_HI  = 3'd7;

  typedef struct packed {
    logic [2:0] act;
    logic [7:0] node;
    logic [7:0] other;
    logic       to_null;
    logic [8:0] slice;
  } alloc_req_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] popped;
    logic [8:0] count;
    logic       empty;
  } alloc_rsp_t;

  typedef struct packed {
    int         pool;
    alloc_req_t req;
    bit         typed;
    alloc_rsp_t rsp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic [2:0] action;
  logic [IDX_W-1:0] node_index;
  logic [IDX_W-1:0] other_node;
  logic link_to_null;
  logic [CNT_W-1:0] slice_count;
  logic done;
  logic ok;
  logic [IDX_W-1:0] popped_node;
  logic [CNT_W-1:0] free_count;
  logic list_empty;
  logic cfg_valid;
  logic cfg_ready;
  logic [CNT_W-1:0] cfg_data;

  free_list_node_allocator uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .node_index(node_index), .other_node(other_node),
    .link_to_null(link_to_null), .slice_count(slice_count),
    .done(done), .ok(ok), .popped_node(popped_node), .free_count(free_count),
    .list_empty(list_empty),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // allocator shadow state
  logic [8:0] pool_shadow;
  logic [7:0] list_head;
  logic       list_live;
  logic [8:0] link_mem [NODE_LIMIT];
  bit         link_set [NODE_LIMIT];
  logic [8:0] free_nodes;

  alloc_rsp_t due_results [$];
  alloc_req_t chain_q [$];
  dir_row_t   dir_rows [$];

  int mismatches;
  int items_sent;
  int results_seen;
  int pops_granted;
  int inits_done;
  int cfg_writes;
  int idle_cycles;
  bit burst;

  function automatic logic [8:0] add_capped(logic [8:0] a, logic [8:0] b);
    int s = int'(a) + int'(b);
    return (s > NODE_LIMIT) ? 9'(NODE_LIMIT) : 9'(s);
  endfunction

  function automatic alloc_rsp_t alloc_predict(alloc_req_t r);
    alloc_rsp_t a;
    int n;
    a = '0;
    case (r.act)
      ACT_INIT: begin
        if (pool_shadow != 0) begin
          n = (pool_shadow > NODE_LIMIT) ? NODE_LIMIT : int'(pool_shadow);
          link_mem[0] = NULL_LINK;
          link_set[0] = 1;
          for (int i = 1; i < n; i++) begin
            link_mem[i] = 9'(i - 1);
            link_set[i] = 1;
          end
          list_head = 8'(n - 1);
          list_live = 1'b1;
          free_nodes = 9'(n);
          a.ok = 1'b1;
          inits_done++;
        end
      end
      ACT_POP: begin
        if (list_live) begin
          a.popped = list_head;
          if (link_mem[list_head][8]) begin
            list_live = 1'b0;
            list_head = '0;
          end else begin
            list_head = link_mem[list_head][7:0];
          end
          if (free_nodes != 0) free_nodes = free_nodes - 1'b1;
          a.ok = 1'b1;
          pops_granted++;
        end
      end
      ACT_PUSH: begin
        link_mem[r.node] = list_live ? {1'b0, list_head} : NULL_LINK;
        link_set[r.node] = 1;
        list_head = r.node;
        list_live = 1'b1;
        free_nodes = add_capped(free_nodes, 9'd1);
        a.ok = 1'b1;
      end
      ACT_SPLICE: begin
        link_mem[r.node] = list_live ? {1'b0, list_head} : NULL_LINK;
        link_set[r.node] = 1;
        list_head = r.other;
        list_live = 1'b1;
        free_nodes = add_capped(free_nodes, r.slice);
        a.ok = 1'b1;
      end
      ACT_SET_LINK: begin
        link_mem[r.node] = r.to_null ? NULL_LINK : {1'b0, r.other};
        link_set[r.node] = 1;
        a.ok = 1'b1;
      end
      default: ;
    endcase
    a.count = free_nodes;
    a.empty = !list_live;
    return a;
  endfunction

  function automatic int pick_gap();
    int r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic note_mismatch(string field, int want, int got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch on %s: expected %0d, got %0d", $time, field, want, got);
  endtask

  task automatic add_row(input int pool, input logic [2:0] act, input logic [7:0] node,
                         input logic [7:0] other, input logic nul, input logic [8:0] slice,
                         input bit typed, input logic ok_w, input logic [7:0] pop_w,
                         input logic [8:0] cnt_w, input logic emp_w);
    dir_row_t d;
    d.pool = pool;
    d.req = '{act, node, other, nul, slice};
    d.typed = typed;
    d.rsp = '{ok_w, pop_w, cnt_w, emp_w};
    dir_rows.push_back(d);
  endtask

  task automatic send(input alloc_req_t r, input bit typed, input alloc_rsp_t fixed);
    alloc_rsp_t predicted;
    int gap;
    @(negedge clk);
    start <= 1'b1;
    action <= r.act;
    node_index <= r.node;
    other_node <= r.other;
    link_to_null <= r.to_null;
    slice_count <= r.slice;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = alloc_predict(r);
    due_results.push_back(typed ? fixed : predicted);
    items_sent++;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic write_pool(input logic [8:0] value);
    int gap;
    @(negedge clk);
    start <= 1'b0;
    while (due_results.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    gap = pick_gap();
    repeat (gap) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pool_shadow = value;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic plan_request(output alloc_req_t r);
    alloc_req_t c;
    logic [7:0] members [5];
    int pick;
    int len;
    r = '{3'(ACT_POP), 8'($urandom), 8'($urandom), 1'($urandom), 9'($urandom_range(0, 256))};
    if (chain_q.size() != 0) begin
      r = chain_q.pop_front();
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        r.act = ACT_INIT;
      end else if (pick < 40) begin
        r.act = ACT_POP;
      end else if (pick < 60) begin
        r.act = ACT_PUSH;
      end else if (pick < 78) begin
        // link a short chain, then splice it in front of the list
        len = $urandom_range(1, 5);
        foreach (members[i]) members[i] = 8'($urandom);
        for (int i = 0; i < len - 1; i++) begin
          c = r;
          c.act = ACT_SET_LINK;
          c.node = members[i];
          c.other = members[i + 1];
          c.to_null = 1'b0;
          chain_q.push_back(c);
        end
        c = r;
        c.act = ACT_SPLICE;
        c.node = members[len - 1];
        c.other = members[0];
        c.slice = ($urandom_range(0, 19) == 0) ? 9'($urandom_range(0, 256)) : 9'(len);
        chain_q.push_back(c);
        r = chain_q.pop_front();
      end else if (pick < 92) begin
        r.act = ACT_SET_LINK;
      end else if (pick < 96) begin
        r.act = ACT_SPLICE;
      end else begin
        r.act = 3'($urandom_range(ACT_BAD_LO, ACT_BAD_HI));
      end
      // never pop a head whose link was not written: set it first
      if (r.act == ACT_POP && list_live && !link_set[list_head]) begin
        r.act = ACT_SET_LINK;
        r.node = list_head;
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    alloc_rsp_t got;
    alloc_rsp_t want;
    if (!rst && done) begin
      results_seen++;
      got = '{ok, popped_node, free_count, list_empty};
      if (due_results.size() == 0) begin
        note_mismatch("unexpected result, ok", -1, int'(got.ok));
      end else begin
        want = due_results.pop_front();
        if (got.ok !== want.ok) note_mismatch("ok", want.ok, got.ok);
        if (got.popped !== want.popped) note_mismatch("popped_node", want.popped, got.popped);
        if (got.count !== want.count) note_mismatch("free_count", want.count, got.count);
        if (got.empty !== want.empty) note_mismatch("list_empty", want.empty, got.empty);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t watchdog: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("[free_list_node_allocator] ERROR");
      $finish;
    end
  end

  initial begin
    int pool_plan [13] = '{1, 256, 2, 511, 0, 3, RANDOM_POOL, 255, 257, 1,
                           RANDOM_POOL, 256, 5};
    alloc_req_t r;
    int v;
    rst = 1'b1;
    start = 1'b0;
    action = '0;
    node_index = '0;
    other_node = '0;
    link_to_null = 1'b0;
    slice_count = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    burst = 0;
    pool_shadow = POOL_RESET;
    list_head = '0;
    list_live = 1'b0;
    free_nodes = '0;
    foreach (link_set[i]) link_set[i] = 0;
    foreach (link_mem[i]) link_mem[i] = '0;

    // pool, action, node, other, null, slice, typed, ok, popped, count, empty
    add_row(NO_CFG, ACT_POP,      8'd0,   8'd0,   1'b0, 9'd0,   1, 1'b0, 8'd0,   9'd0,   1'b1);
    add_row(NO_CFG, ACT_PUSH,     8'd0,   8'd0,   1'b0, 9'd0,   1, 1'b1, 8'd0,   9'd1,   1'b0);
    add_row(NO_CFG, ACT_POP,      8'd0,   8'd0,   1'b0, 9'd0,   1, 1'b1, 8'd0,   9'd0,   1'b1);
    add_row(NO_CFG, ACT_BAD_LO,   8'd0,   8'd0,   1'b0, 9'd0,   1, 1'b0, 8'd0,   9'd0,   1'b1);
    add_row(NO_CFG, ACT_BAD_HI,   8'd255, 8'd255, 1'b1, 9'd256, 1, 1'b0, 8'd0,   9'd0,   1'b1);
    add_row(NO_CFG, ACT_INIT,     8'd0,   8'd0,   1'b0, 9'd0,   1, 1'b1, 8'd0,   9'd256, 1'b0);
    add_row(NO_CFG, ACT_POP,      8'd0,   8'd0,   1'b0, 9'd0,   1, 1'b1, 8'd255, 9'd255, 1'b0);
    add_row(NO_CFG, ACT_PUSH,     8'd255, 8'd0,   1'b0, 9'd0,   1, 1'b1, 8'd0,   9'd256, 1'b0);
    add_row(NO_CFG, ACT_PUSH,     8'd128, 8'd0,   1'b0, 9'd0,   1, 1'b1, 8'd0,   9'd256, 1'b0);
    add_row(NO_CFG, ACT_SET_LINK, 8'd255, 8'd0,   1'b0, 9'd0,   0, 1'b0, 8'd0,   9'd0,   1'b0);
    add_row(NO_CFG, ACT_SET_LINK, 8'd0,   8'd255, 1'b1, 9'd0,   0, 1'b0, 8'd0,   9'd0,   1'b0);
    add_row(NO_CFG, ACT_SPLICE,   8'd0,   8'd255, 1'b0, 9'd256, 1, 1'b1, 8'd0,   9'd256, 1'b0);
    add_row(NO_CFG, ACT_POP,      8'd0,   8'd0,   1'b0, 9'd0,   0, 1'b0, 8'd0,   9'd0,   1'b0);
    add_row(NO_CFG, ACT_BAD_MID,  8'd17,  8'd34,  1'b0, 9'd9,   0, 1'b0, 8'd0,   9'd0,   1'b0);
    add_row(0,      ACT_INIT,     8'd0,   8'd0,   1'b0, 9'd0,   0, 1'b0, 8'd0,   9'd0,   1'b0);
    add_row(1,      ACT_INIT,     8'd0,   8'd0,   1'b0, 9'd0,   1, 1'b1, 8'd0,   9'd1,   1'b0);
    add_row(NO_CFG, ACT_POP,      8'd0,   8'd0,   1'b0, 9'd0,   1, 1'b1, 8'd0,   9'd0,   1'b1);
    add_row(NO_CFG, ACT_SPLICE,   8'd9,   8'd7,   1'b0, 9'd0,   1, 1'b1, 8'd0,   9'd0,   1'b0);
    add_row(NO_CFG, ACT_SET_LINK, 8'd7,   8'd0,   1'b1, 9'd0,   1, 1'b1, 8'd0,   9'd0,   1'b0);
    add_row(NO_CFG, ACT_POP,      8'd0,   8'd0,   1'b0, 9'd0,   1, 1'b1, 8'd7,   9'd0,   1'b1);
    add_row(511,    ACT_INIT,     8'd0,   8'd0,   1'b0, 9'd0,   1, 1'b1, 8'd0,   9'd256, 1'b0);
    add_row(NO_CFG, ACT_POP,      8'd0,   8'd0,   1'b0, 9'd0,   0, 1'b0, 8'd0,   9'd0,   1'b0);
    add_row(NO_CFG, ACT_SPLICE,   8'd200, 8'd100, 1'b0, 9'd1,   0, 1'b0, 8'd0,   9'd0,   1'b0);
    add_row(NO_CFG, ACT_POP,      8'd0,   8'd0,   1'b0, 9'd0,   0, 1'b0, 8'd0,   9'd0,   1'b0);
    add_row(2,      ACT_INIT,     8'd0,   8'd0,   1'b0, 9'd0,   0, 1'b0, 8'd0,   9'd0,   1'b0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].pool != NO_CFG) write_pool(9'(dir_rows[i].pool));
      send(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
    end

    foreach (pool_plan[ph]) begin
      v = (pool_plan[ph] == RANDOM_POOL) ? $urandom_range(1, 300) : pool_plan[ph];
      chain_q.delete();
      write_pool(9'(v));
      r = '{3'(ACT_INIT), 8'($urandom), 8'($urandom), 1'($urandom), 9'($urandom_range(0, 256))};
      send(r, 0, '0);
      for (int k = 1; k < PHASE_ITEMS || chain_q.size() != 0; k++) begin
        if (k % 25 == 0) burst = ($urandom_range(0, 3) == 0);
        plan_request(r);
        send(r, 0, '0);
      end
      burst = 0;
    end

    @(negedge clk);
    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Run covered %0d items and %0d results, %0d granted pops, %0d inits,",
             items_sent, results_seen, pops_granted, inits_done);
    $display("%0d pool_size writes and %0d mismatches.", cfg_writes, mismatches);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("[free_list_node_allocator] OK");
    end else begin
      $display("[free_list_node_allocator] ERROR");
    end
    $finish;
  end

endmodule
